[design/wplm_pkg.sv]
// shared types and constants of the windowed peak level monitor
package wplm_pkg;

    typedef enum logic [1:0] {
        CLS_NORMAL = 2'd0,
        CLS_HIGH   = 2'd1,
        CLS_LOW    = 2'd2,
        CLS_MUTE   = 2'd3
    } level_class_t;

    localparam int unsigned CFG_INDEX_BITS = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_HIGH_LEVEL      = 3'd0,
        REG_LOW_LEVEL       = 3'd1,
        REG_MUTE_LEVEL      = 3'd2,
        REG_WINDOW_LENGTH   = 3'd3,
        REG_MIN_RUN_WINDOWS = 3'd4,
        REG_STEREO_MODE     = 3'd5
    } cfg_reg_t;

    localparam logic [15:0] HIGH_LEVEL_RESET      = 16'd29204;
    localparam logic [15:0] LOW_LEVEL_RESET       = 16'd3277;
    localparam logic [15:0] MUTE_LEVEL_RESET      = 16'd33;
    localparam logic [15:0] WINDOW_LENGTH_RESET   = 16'd1764;
    localparam logic [15:0] MIN_RUN_WINDOWS_RESET = 16'd25;
    localparam logic        STEREO_MODE_RESET     = 1'b1;

    localparam logic [15:0] REPORT_MAX = 16'hFFFF;

    // report queue
    localparam int unsigned OUT_DEPTH = 4;
    localparam int unsigned OUT_PTR_BITS = 2;
    localparam int unsigned OUT_CNT_BITS = 3;

    typedef struct packed {
        logic         channel;
        level_class_t level_class;
        logic [15:0]  run_windows;
        logic [15:0]  window_index;
        logic         last;
    } report_t;

endpackage

[design/windowed_peak_level_monitor.sv]
// top level of the windowed peak level monitor
//
//  channel   signals                               direction  transfer when
//  input     in_valid in_stall left/right_sample   in         in_valid && !in_stall
//  output    out_valid out_stall channel..last     out        out_valid && !out_stall
//  config    cfg_valid cfg_ready cfg_index cfg_data in        cfg_valid && cfg_ready
//
// one frame per cycle while in_stall is low: a frame is registered, then processed in the next cycle
// (magnitude, peak, window end, classification, run update) into a 4-entry queue
// reports are written to the queue as the frame is processed, then leave it one per cycle while out_stall is low
// in_stall rises while the queue, with two slots held for a registered frame, could not take two more reports
// reset clears all counters, peaks, runs and the queue; registers take defaults
module windowed_peak_level_monitor #(
    parameter int unsigned SAMPLE_BITS = 16,
    parameter int unsigned COUNT_BITS  = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [SAMPLE_BITS-1:0]          left_sample,
    input  logic signed [SAMPLE_BITS-1:0]          right_sample,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic                                   channel,
    output logic [1:0]                             level_class,
    output logic [15:0]                            run_windows,
    output logic [15:0]                            window_index,
    output logic                                   last,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [wplm_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [15:0]                            cfg_data
);

    localparam int unsigned LW = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
    localparam int unsigned RW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // configuration
    logic [15:0] high_level_reg, low_level_reg, mute_level_reg;
    logic [15:0] window_length_reg, min_run_windows_reg;
    logic        stereo_mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_level_reg      <= wplm_pkg::HIGH_LEVEL_RESET;
            low_level_reg       <= wplm_pkg::LOW_LEVEL_RESET;
            mute_level_reg      <= wplm_pkg::MUTE_LEVEL_RESET;
            window_length_reg   <= wplm_pkg::WINDOW_LENGTH_RESET;
            min_run_windows_reg <= wplm_pkg::MIN_RUN_WINDOWS_RESET;
            stereo_mode_reg     <= wplm_pkg::STEREO_MODE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                wplm_pkg::REG_HIGH_LEVEL:      high_level_reg      <= cfg_data;
                wplm_pkg::REG_LOW_LEVEL:       low_level_reg       <= cfg_data;
                wplm_pkg::REG_MUTE_LEVEL:      mute_level_reg      <= cfg_data;
                wplm_pkg::REG_WINDOW_LENGTH:   window_length_reg   <= cfg_data;
                wplm_pkg::REG_MIN_RUN_WINDOWS: min_run_windows_reg <= cfg_data;
                wplm_pkg::REG_STEREO_MODE:     stereo_mode_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // input register
    logic                   s1_valid_reg;
    logic [SAMPLE_BITS-1:0] s1_sample_reg [2];
    logic                   in_xfer;
    logic [wplm_pkg::OUT_CNT_BITS-1:0] count_reg;
    logic [wplm_pkg::OUT_CNT_BITS:0]   pending;

    assign pending  = {1'b0, count_reg} + (s1_valid_reg ? 4'd2 : 4'd0);
    assign in_stall = (pending > 4'(wplm_pkg::OUT_DEPTH - 2));
    assign in_xfer  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_xfer;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_sample_reg[0] <= left_sample;
            s1_sample_reg[1] <= right_sample;
        end
    end

    function automatic wplm_pkg::level_class_t classify(input logic [SAMPLE_BITS-1:0] peak,
                                                        input logic [15:0] hi,
                                                        input logic [15:0] lo,
                                                        input logic [15:0] mu);
        logic [LW-1:0] p;
        p = LW'(peak);
        if (p > LW'(hi))
            return wplm_pkg::CLS_HIGH;
        else if (p > LW'(lo))
            return wplm_pkg::CLS_NORMAL;
        else if (p > LW'(mu))
            return wplm_pkg::CLS_LOW;
        else
            return wplm_pkg::CLS_MUTE;
    endfunction

    // frame processing state
    logic [COUNT_BITS-1:0]     frame_count_reg, frame_count_next;
    logic [15:0]               window_counter_reg, window_counter_next;
    logic [SAMPLE_BITS-1:0]    peak_reg [2];
    logic [SAMPLE_BITS-1:0]    peak_next [2];
    wplm_pkg::level_class_t    cls_reg [2];
    wplm_pkg::level_class_t    cls_next [2];
    logic [COUNT_BITS-1:0]     run_reg [2];
    logic [COUNT_BITS-1:0]     run_next [2];
    logic                      due [2];
    wplm_pkg::report_t         rep [2];

    logic [COUNT_BITS-1:0]     fc_inc;
    logic [15:0]               win_len;
    logic                      win_end;
    logic [SAMPLE_BITS-1:0]    mag [2];
    logic [SAMPLE_BITS-1:0]    peak_upd [2];
    logic                      active [2];
    wplm_pkg::level_class_t    now_cls [2];
    logic [RW-1:0]             run_ext [2];

    always_comb
    begin
        win_len = (window_length_reg == 16'd0) ? 16'd1 : window_length_reg;
        fc_inc  = frame_count_reg + COUNT_BITS'(1);
        win_end = (RW'(fc_inc) >= RW'(win_len)) || (fc_inc == '0);

        frame_count_next    = frame_count_reg;
        window_counter_next = window_counter_reg;

        for (int c = 0; c < 2; c++)
        begin
            active[c]   = (c == 0) || stereo_mode_reg;
            mag[c]      = s1_sample_reg[c][SAMPLE_BITS-1] ? (~s1_sample_reg[c] + 1'b1)
                                                          : s1_sample_reg[c];
            peak_upd[c] = (active[c] && (mag[c] > peak_reg[c])) ? mag[c] : peak_reg[c];
            now_cls[c]  = classify(peak_upd[c], high_level_reg, low_level_reg,
                                   mute_level_reg);
            run_ext[c]  = RW'(run_reg[c]);

            peak_next[c] = peak_reg[c];
            cls_next[c]  = cls_reg[c];
            run_next[c]  = run_reg[c];
            due[c]       = 1'b0;

            rep[c].channel      = c[0];
            rep[c].level_class  = cls_reg[c];
            rep[c].run_windows  = (run_ext[c] > RW'(wplm_pkg::REPORT_MAX))
                                  ? wplm_pkg::REPORT_MAX : run_ext[c][15:0];
            rep[c].window_index = window_counter_reg;
            rep[c].last         = 1'b1;

            if (s1_valid_reg)
            begin
                if (win_end)
                begin
                    peak_next[c] = '0;
                    if (active[c])
                    begin
                        if (run_reg[c] == '0)
                        begin
                            cls_next[c] = now_cls[c];
                            run_next[c] = COUNT_BITS'(1);
                        end
                        else if ((cls_reg[c] == now_cls[c]) &&
                                 (now_cls[c] != wplm_pkg::CLS_NORMAL))
                        begin
                            if (run_reg[c] != COUNT_MAX)
                                run_next[c] = run_reg[c] + COUNT_BITS'(1);
                        end
                        else
                        begin
                            due[c]      = (run_ext[c] >= RW'(min_run_windows_reg));
                            cls_next[c] = wplm_pkg::CLS_NORMAL;
                            run_next[c] = '0;
                        end
                    end
                end
                else
                begin
                    peak_next[c] = peak_upd[c];
                end
            end
        end

        rep[0].last = !due[1];

        if (s1_valid_reg)
        begin
            if (win_end)
            begin
                frame_count_next    = '0;
                window_counter_next = window_counter_reg + 16'd1;
            end
            else
            begin
                frame_count_next = fc_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg    <= '0;
            window_counter_reg <= '0;
            for (int c = 0; c < 2; c++)
            begin
                peak_reg[c] <= '0;
                cls_reg[c]  <= wplm_pkg::CLS_NORMAL;
                run_reg[c]  <= '0;
            end
        end
        else
        begin
            frame_count_reg    <= frame_count_next;
            window_counter_reg <= window_counter_next;
            for (int c = 0; c < 2; c++)
            begin
                peak_reg[c] <= peak_next[c];
                cls_reg[c]  <= cls_next[c];
                run_reg[c]  <= run_next[c];
            end
        end
    end

    // report queue
    wplm_pkg::report_t                  queue_reg [wplm_pkg::OUT_DEPTH];
    logic [wplm_pkg::OUT_PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [wplm_pkg::OUT_PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [wplm_pkg::OUT_CNT_BITS-1:0]  count_next;
    logic [wplm_pkg::OUT_PTR_BITS-1:0]  wr_ptr_second;
    logic [1:0]                         push_count;
    logic                               out_xfer;
    wplm_pkg::report_t                  head;

    assign out_valid     = (count_reg != '0);
    assign out_xfer      = out_valid && !out_stall;
    assign push_count    = {1'b0, due[0]} + {1'b0, due[1]};
    assign wr_ptr_second = wr_ptr_reg + {{(wplm_pkg::OUT_PTR_BITS-1){1'b0}}, due[0]};

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + wplm_pkg::OUT_PTR_BITS'(push_count);
        rd_ptr_next = rd_ptr_reg + {{(wplm_pkg::OUT_PTR_BITS-1){1'b0}}, out_xfer};
        count_next  = count_reg + wplm_pkg::OUT_CNT_BITS'(push_count)
                      - {{(wplm_pkg::OUT_CNT_BITS-1){1'b0}}, out_xfer};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (due[0])
            queue_reg[wr_ptr_reg] <= rep[0];
        if (due[1])
            queue_reg[wr_ptr_second] <= rep[1];
    end

    assign head         = queue_reg[rd_ptr_reg];
    assign channel      = head.channel;
    assign level_class  = head.level_class;
    assign run_windows  = head.run_windows;
    assign window_index = head.window_index;
    assign last         = head.last;

endmodule
